// ----- sv/gtsd_pkg.sv -----
// shared types, constants and tables for the gregorian to shamsi date converter
package gtsd_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned SYEAR_W = 13;

  typedef logic [DOY_W-1:0]          doy_t;
  typedef logic signed [SYEAR_W-1:0] syear_t;

  // day of the shamsi year and the signed shamsi year, between the two halves
  typedef struct packed {
    syear_t syear;
    doy_t   doy;
  } day_count_t;

  // days before each gregorian month in a common year, index 12 is a full year
  localparam doy_t GREG_START [13] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  localparam doy_t SHAM_START [12] = '{
    9'd0,   9'd31,  9'd62,  9'd93,  9'd124, 9'd155,
    9'd186, 9'd216, 9'd246, 9'd276, 9'd306, 9'd336
  };

  // last day of each shamsi month, esfand as in a common year
  localparam doy_t SHAM_END [12] = '{
    9'd31,  9'd62,  9'd93,  9'd124, 9'd155, 9'd186,
    9'd216, 9'd246, 9'd276, 9'd306, 9'd336, 9'd365
  };

  localparam int unsigned LAST_MONTH = 11;
  localparam int unsigned FEB_INDEX  = 2;

  localparam doy_t GREG_LEAP_THR   = 9'd80;
  localparam doy_t GREG_COMMON_THR = 9'd79;
  localparam doy_t NEW_YEAR_SHIFT  = 9'd286;

  // divisibility by 25: y * inv(25) mod 2^12 stays at or below 4095 / 25
  localparam logic [YEAR_W-1:0] INV25   = 12'd3113;
  localparam logic [YEAR_W-1:0] Q25_MAX = 12'd163;

  localparam syear_t EPOCH_AFTER  = 13'sd621;
  localparam syear_t EPOCH_BEFORE = 13'sd622;

  localparam syear_t SH_BASE_POS = 13'sd474;
  localparam syear_t SH_BASE_NEG = 13'sd473;
  localparam syear_t SH_CYCLE    = 13'sd2820;

  localparam int unsigned SH_LEAP_NUM = 682;
  localparam int unsigned SH_LEAP_DEN = 2816;
  // 682 * k mod 2816 repeats every 2816 / gcd(682, 2816) = 128 values of k
  localparam int unsigned SH_LEAP_PERIOD = 128;
  localparam int unsigned SH_IDX_W       = 7;
  localparam int unsigned SH_POS_W       = 12;

  function automatic logic [SH_LEAP_PERIOD-1:0] sham_leap_table();
    logic [SH_LEAP_PERIOD-1:0] tbl;
    int unsigned acc;
    tbl = '0;
    acc = 0;
    for (int t = 0; t < SH_LEAP_PERIOD; t++) begin
      tbl[t] = (acc < SH_LEAP_NUM);
      acc = acc + SH_LEAP_NUM;
      if (acc >= SH_LEAP_DEN) begin
        acc = acc - SH_LEAP_DEN;
      end
    end
    return tbl;
  endfunction

  // indexed by the cycle position mod 128 (the +474+38 offset is a multiple of 128)
  localparam logic [SH_LEAP_PERIOD-1:0] SH_LEAP_TBL = sham_leap_table();

endpackage

// ----- sv/gtsd_in_if.sv -----
// request channel carrying one gregorian date
interface gtsd_in_if
  import gtsd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  greg_year;
  logic [MONTH_W-1:0] greg_month;
  logic [DAY_W-1:0]   greg_day;

  modport source (output valid, output greg_year, output greg_month, output greg_day,
                  input ready);
  modport sink   (input valid, input greg_year, input greg_month, input greg_day,
                  output ready);
endinterface

// ----- sv/gtsd_out_if.sv -----
// result channel carrying one shamsi date
interface gtsd_out_if
  import gtsd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  shamsi_year;
  logic [MONTH_W-1:0] shamsi_month;
  logic [DAY_W-1:0]   shamsi_day;

  modport source (output valid, output shamsi_year, output shamsi_month,
                  output shamsi_day, input ready);
  modport sink   (input valid, input shamsi_year, input shamsi_month,
                  input shamsi_day, output ready);
endinterface

// ----- sv/gtsd_day_count.sv -----
// gregorian day of year, leap rule and shift to the shamsi new year
module gtsd_day_count
  import gtsd_pkg::*;
(
  input  logic [YEAR_W-1:0]  greg_year,
  input  logic [MONTH_W-1:0] greg_month,
  input  logic [DAY_W-1:0]   greg_day,
  output day_count_t         dc
);

  logic [2*YEAR_W-1:0] prod;
  logic                div4;
  logic                div25;
  logic                div100;
  logic                div400;
  logic                gleap;
  logic [3:0]          prior_months;
  doy_t                doy;
  doy_t                thr;
  syear_t              gy_s;

  always_comb begin
    prod   = (2*YEAR_W)'(greg_year) * (2*YEAR_W)'(INV25);
    div25  = (prod[YEAR_W-1:0] <= Q25_MAX);
    div4   = (greg_year[1:0] == 2'b00);
    div100 = div4 && div25;
    div400 = div25 && (greg_year[3:0] == 4'b0000);
    gleap  = (div4 && !div100) || div400;

    // month zero counts like january, months past twelve count the whole year
    if (greg_month == 4'd0) begin
      prior_months = 4'd0;
    end else if (greg_month >= 4'd13) begin
      prior_months = 4'd12;
    end else begin
      prior_months = greg_month - 4'd1;
    end

    doy = GREG_START[prior_months] + doy_t'(greg_day)
        + doy_t'(gleap && (prior_months >= 4'(FEB_INDEX)));
    thr  = gleap ? GREG_LEAP_THR : GREG_COMMON_THR;
    gy_s = syear_t'({1'b0, greg_year});

    if (doy > thr) begin
      dc.doy   = doy - thr;
      dc.syear = gy_s - EPOCH_AFTER;
    end else begin
      dc.doy   = doy + NEW_YEAR_SHIFT;
      dc.syear = gy_s - EPOCH_BEFORE;
    end
  end

endmodule

// ----- sv/gtsd_month_map.sv -----
// shamsi leap test and placement of the day count in the month table
module gtsd_month_map
  import gtsd_pkg::*;
(
  input  day_count_t         dc,
  output logic [YEAR_W-1:0]  shamsi_year,
  output logic [MONTH_W-1:0] shamsi_month,
  output logic [DAY_W-1:0]   shamsi_day
);

  syear_t              base;
  syear_t              folded;
  logic [SH_POS_W-1:0] cyc_pos;
  logic                sleap;
  doy_t                end_day;

  always_comb begin
    base = dc.syear - ((dc.syear > 13'sd0) ? SH_BASE_POS : SH_BASE_NEG);

    // floor mod 2820, base lies within 2820 of either end of the range, so a single fold suffices
    if (base < 13'sd0) begin
      folded = base + SH_CYCLE;
    end else if (base >= SH_CYCLE) begin
      folded = base - SH_CYCLE;
    end else begin
      folded = base;
    end
    cyc_pos = folded[SH_POS_W-1:0];
    sleap   = SH_LEAP_TBL[cyc_pos[SH_IDX_W-1:0]];

    shamsi_year  = dc.syear[YEAR_W-1:0];
    shamsi_month = '0;
    shamsi_day   = '0;
    end_day      = '0;
    // descending so the first month that holds the day wins
    for (int i = LAST_MONTH; i >= 0; i--) begin
      end_day = SHAM_END[i] + doy_t'((i == LAST_MONTH) && sleap);
      if (dc.doy <= end_day) begin
        shamsi_month = MONTH_W'(i + 1);
        shamsi_day   = DAY_W'(dc.doy - SHAM_START[i]);
      end
    end
  end

endmodule

// ----- sv/gregorian_to_shamsi_date_core.sv -----
// gregorian to shamsi date converter top level
// request accept to result valid passes the input register, then the result register
// throughput: one request per cycle, limited only by the result side's ready
// the conversion is one combinational pass between the two registers
// rst is synchronous active high and clears both valid flags, payload is not reset
module gregorian_to_shamsi_date_core
  import gtsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gtsd_in_if.sink     din,
  gtsd_out_if.source  dout
);

  logic               s1_valid;
  logic [YEAR_W-1:0]  s1_year;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;

  logic               out_valid;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;

  logic               advance;
  day_count_t         dc;
  logic [YEAR_W-1:0]  res_year;
  logic [MONTH_W-1:0] res_month;
  logic [DAY_W-1:0]   res_day;

  assign advance   = !out_valid || dout.ready;
  assign din.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_year  <= din.greg_year;
      s1_month <= din.greg_month;
      s1_day   <= din.greg_day;
    end
  end

  gtsd_day_count u_day_count (
    .greg_year  (s1_year),
    .greg_month (s1_month),
    .greg_day   (s1_day),
    .dc         (dc)
  );

  gtsd_month_map u_month_map (
    .dc           (dc),
    .shamsi_year  (res_year),
    .shamsi_month (res_month),
    .shamsi_day   (res_day)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_year  <= res_year;
      out_month <= res_month;
      out_day   <= res_day;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.shamsi_year  = out_year;
  assign dout.shamsi_month = out_month;
  assign dout.shamsi_day   = out_day;

endmodule

// ----- sv/gtsd_checker.sv -----
// port level checks for the date converter, bound to the top level
module gtsd_checker
  import gtsd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [YEAR_W-1:0]  shamsi_year,
  input logic [MONTH_W-1:0] shamsi_month,
  input logic [DAY_W-1:0]   shamsi_day
);

  // a stalled result keeps its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shamsi_year)
      && $stable(shamsi_month) && $stable(shamsi_day))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // an empty result register never blocks a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request blocked with empty result stage");

  a_no_fit_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((shamsi_month == 4'd0) == (shamsi_day == 5'd0)))
    else $error("month and day disagree on a date that fits no month");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (shamsi_month > 4'd6) |-> (shamsi_month <= 4'd12) && (shamsi_day <= 5'd30))
    else $error("month or day out of range");

endmodule

bind gregorian_to_shamsi_date_core gtsd_checker u_gtsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (din.ready),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .shamsi_year  (dout.shamsi_year),
  .shamsi_month (dout.shamsi_month),
  .shamsi_day   (dout.shamsi_day)
);
